@@ src/rbei_pkg.sv @@
// Shared types, constants and arithmetic helpers of the rigid body integrator.
package rbei_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int MUL_W = 33;
	localparam int PROD_W = 64;
	localparam int SD_NUM_W = 64;
	localparam int SD_DEN_W = 32;
	localparam int CORDIC_STEPS = 15;
	localparam int MOP_COUNT = 15;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008219;
	localparam logic signed [15:0] Q14_ONE = 16'sd16384;

	typedef enum logic [1:0] {
		CMD_PUSH,
		CMD_DRAG,
		CMD_TURN,
		CMD_UPDATE
	} cmd_t;

	typedef enum logic {
		SD_SQRT,
		SD_DIV
	} sd_mode_t;

	// operand sources of the rotation matrix sequence
	typedef enum logic [3:0] {
		SRC_SP, SRC_CP, SRC_SY, SRC_CY, SRC_SR, SRC_CR, SRC_M0, SRC_M1, SRC_ONE
	} src_t;

	typedef enum logic [3:0] {
		DST_R00, DST_R01, DST_R02, DST_R10, DST_R11, DST_R12, DST_R20, DST_R21, DST_R22,
		DST_M0, DST_M1
	} dst_t;

	typedef struct packed {
		src_t src_a;
		src_t src_b;
		logic shl;
		logic neg;
		logic first;
		logic last;
		dst_t dst;
	} mop_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic [30:0]        drag_coefficient;
		logic signed [15:0] turn_pitch;
		logic signed [15:0] turn_yaw;
		logic signed [15:0] turn_roll;
		logic [16:0]        time_step;
	} item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] rot_00;
		logic signed [15:0] rot_01;
		logic signed [15:0] rot_02;
		logic signed [15:0] rot_10;
		logic signed [15:0] rot_11;
		logic signed [15:0] rot_12;
		logic signed [15:0] rot_20;
		logic signed [15:0] rot_21;
		logic signed [15:0] rot_22;
	} result_t;

	function automatic logic [13:0] atan_unit(input logic [3:0] i);
		logic [13:0] r;
		case (i)
			4'd0:    r = 14'd8192;
			4'd1:    r = 14'd4836;
			4'd2:    r = 14'd2555;
			4'd3:    r = 14'd1297;
			4'd4:    r = 14'd651;
			4'd5:    r = 14'd326;
			4'd6:    r = 14'd163;
			4'd7:    r = 14'd81;
			4'd8:    r = 14'd41;
			4'd9:    r = 14'd20;
			4'd10:   r = 14'd10;
			4'd11:   r = 14'd5;
			4'd12:   r = 14'd3;
			4'd13:   r = 14'd1;
			4'd14:   r = 14'd1;
			default: r = 14'd0;
		endcase
		return r;
	endfunction

	// each step: acc = (first ? 0 : acc) +- (a * b) << (shl ? 14 : 0)
	function automatic mop_t mop_rom(input logic [3:0] idx);
		mop_t m;
		case (idx)
			4'd0:    m = '{SRC_SP, SRC_SR, 1'b0, 1'b0, 1'b1, 1'b1, DST_M0};
			4'd1:    m = '{SRC_SP, SRC_CR, 1'b0, 1'b0, 1'b1, 1'b1, DST_M1};
			4'd2:    m = '{SRC_CY, SRC_CR, 1'b1, 1'b0, 1'b1, 1'b0, DST_R00};
			4'd3:    m = '{SRC_SY, SRC_M0, 1'b0, 1'b0, 1'b0, 1'b1, DST_R00};
			4'd4:    m = '{SRC_CY, SRC_SR, 1'b1, 1'b1, 1'b1, 1'b0, DST_R01};
			4'd5:    m = '{SRC_SY, SRC_M1, 1'b0, 1'b0, 1'b0, 1'b1, DST_R01};
			4'd6:    m = '{SRC_SY, SRC_CP, 1'b1, 1'b0, 1'b1, 1'b1, DST_R02};
			4'd7:    m = '{SRC_SR, SRC_CP, 1'b1, 1'b0, 1'b1, 1'b1, DST_R10};
			4'd8:    m = '{SRC_CR, SRC_CP, 1'b1, 1'b0, 1'b1, 1'b1, DST_R11};
			4'd9:    m = '{SRC_SP, SRC_ONE, 1'b1, 1'b1, 1'b1, 1'b1, DST_R12};
			4'd10:   m = '{SRC_SY, SRC_CR, 1'b1, 1'b1, 1'b1, 1'b0, DST_R20};
			4'd11:   m = '{SRC_CY, SRC_M0, 1'b0, 1'b0, 1'b0, 1'b1, DST_R20};
			4'd12:   m = '{SRC_SR, SRC_SY, 1'b1, 1'b0, 1'b1, 1'b0, DST_R21};
			4'd13:   m = '{SRC_CY, SRC_M1, 1'b0, 1'b0, 1'b0, 1'b1, DST_R21};
			4'd14:   m = '{SRC_CY, SRC_CP, 1'b1, 1'b0, 1'b1, 1'b1, DST_R22};
			default: m = '{SRC_ONE, SRC_ONE, 1'b0, 1'b0, 1'b1, 1'b0, DST_R22};
		endcase
		return m;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647)
			return 32'sh7FFFFFFF;
		if (x < -66'sd2147483648)
			return 32'sh80000000;
		return x[31:0];
	endfunction

	function automatic logic signed [31:0] clamp_ms(input logic signed [32:0] x,
			input logic [30:0] ms);
		logic signed [32:0] hi;
		logic signed [32:0] lo;
		hi = $signed({2'b00, ms});
		lo = -hi;
		if (x > hi)
			return hi[31:0];
		if (x < lo)
			return lo[31:0];
		return x[31:0];
	endfunction

	// Q2.28 to Q1.14, round to nearest, clamp, optional sign flip
	function automatic logic signed [15:0] cordic_round(input logic signed [31:0] v,
			input logic neg);
		logic signed [32:0] t;
		logic signed [15:0] r;
		t = (33'(v) + 33'sd8192) >>> 14;
		if (t > 33'sd16384)
			r = Q14_ONE;
		else if (t < -33'sd16384)
			r = -Q14_ONE;
		else
			r = t[15:0];
		return neg ? -r : r;
	endfunction

	// Q3.42 to Q1.14, round half up, clamp
	function automatic logic signed [15:0] q42_to_q14(input logic signed [47:0] v);
		logic signed [47:0] t;
		t = (v + 48'sd134217728) >>> 28;
		if (t > 48'sd16384)
			return Q14_ONE;
		if (t < -48'sd16384)
			return -Q14_ONE;
		return t[15:0];
	endfunction

endpackage

@@ src/rbei_mul.sv @@
// Bit-serial signed multiplier: one bit of the second operand per cycle.
module rbei_mul (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [rbei_pkg::MUL_W-1:0]     a,
	input  logic signed [rbei_pkg::MUL_W-1:0]     b,
	output logic                                  done,
	output logic signed [rbei_pkg::PROD_W-1:0]    prod
);
	import rbei_pkg::*;

	localparam int CNT_W = $clog2(MUL_W + 1);

	logic [MUL_W-1:0]   mag_a_q;
	logic [2*MUL_W-1:0] acc_q;
	logic               neg_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [MUL_W:0]     part;
	logic [PROD_W-1:0]  mag_prod;

	always_comb begin
		part = {1'b0, acc_q[2*MUL_W-1:MUL_W]} + (acc_q[0] ? {1'b0, mag_a_q} : '0);
		mag_prod = acc_q[PROD_W-1:0];
	end

	assign prod = neg_q ? -$signed(mag_prod) : $signed(mag_prod);
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			mag_a_q <= '0;
			acc_q <= '0;
			neg_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mag_a_q <= a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
				acc_q <= {{MUL_W{1'b0}}, (b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b))};
				neg_q <= a[MUL_W-1] ^ b[MUL_W-1];
				cnt_q <= CNT_W'(MUL_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= {part, acc_q[MUL_W-1:1]};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ src/rbei_sqdiv.sv @@
// Shared digit-recurrence unit: integer square root or unsigned division, one digit a cycle.
module rbei_sqdiv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  rbei_pkg::sd_mode_t                mode,
	input  logic [rbei_pkg::SD_NUM_W-1:0]     num,
	input  logic [rbei_pkg::SD_DEN_W-1:0]     den,
	output logic                              done,
	output logic [rbei_pkg::SD_NUM_W-1:0]     quot
);
	import rbei_pkg::*;

	localparam int REM_W = SD_DEN_W + 4;
	localparam int CNT_W = $clog2(SD_NUM_W + 1);

	sd_mode_t            mode_q;
	logic [SD_NUM_W-1:0] num_q;
	logic [SD_DEN_W-1:0] den_q;
	logic [REM_W-1:0]    rem_q;
	logic [SD_NUM_W-1:0] quot_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [REM_W-1:0]    rem_sh;
	logic [REM_W-1:0]    trial;
	logic                fits;

	always_comb begin
		if (mode_q == SD_SQRT) begin
			rem_sh = {rem_q[REM_W-3:0], num_q[SD_NUM_W-1 -: 2]};
			trial = {quot_q[REM_W-3:0], 2'b01};
		end else begin
			rem_sh = {rem_q[REM_W-2:0], num_q[SD_NUM_W-1]};
			trial = {4'b0000, den_q};
		end
		fits = rem_sh >= trial;
	end

	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			mode_q <= SD_SQRT;
			num_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			quot_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mode_q <= mode;
				num_q <= num;
				den_q <= den;
				rem_q <= '0;
				quot_q <= '0;
				cnt_q <= (mode == SD_SQRT) ? CNT_W'(SD_NUM_W / 2) : CNT_W'(SD_NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? rem_sh - trial : rem_sh;
				quot_q <= {quot_q[SD_NUM_W-2:0], fits};
				num_q <= (mode_q == SD_SQRT) ? num_q << 2 : num_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ src/rigid_body_euler_integrator_core.sv @@
// Rigid body integrator top level: body state, command sequencer and result register.
//
//  channel  | direction | handshake                     | payload
//  item     | in        | item_valid / item_stall       | rbei_pkg::item_t
//  result   | out       | result_valid / result_stall   | rbei_pkg::result_t
//  cfg      | in        | cfg_write (no wait)           | cfg_index, cfg_data
//
// Every multiply runs on one bit-serial multiplier; root and divide share one
// digit-recurrence unit. An update runs 9 multiplies, one root, 45 CORDIC steps
// and 15 matrix multiplies in sequence; a turn is applied as the item is taken.
// One item is in work at a time; item_stall is high until it finishes.
// A finished result waits in its register while the next item is taken.
// Reset zeroes the body state and loads max_speed and inverse_mass with 1.0.
module rigid_body_euler_integrator_core #(
	parameter int FRACTION_BITS = rbei_pkg::FRACTION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  rbei_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_stall,
	output rbei_pkg::result_t   result,
	input  logic                cfg_write,
	input  logic                cfg_index,
	input  logic [30:0]         cfg_data
);
	import rbei_pkg::*;

	localparam int THR = ((1 << FRACTION_BITS) + 50) / 100;
	localparam logic REG_MAX_SPEED = 1'b0;
	localparam logic REG_INV_MASS = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE, S_PUSH, S_PUSH_W, S_SQ, S_SQ_W, S_ROOT_W, S_DRAG, S_DRAG_MW, S_DRAG_DW,
		S_VEL, S_VEL_W, S_POS, S_POS_W, S_CINIT, S_CORD, S_CFIN, S_MAT, S_MAT_W, S_EMIT
	} state_t;

	state_t             state_q;
	logic [30:0]        max_speed_q;
	logic [30:0]        inv_mass_q;
	item_t              in_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] acc_q [3];
	logic [15:0]        ang_q [3];
	logic signed [15:0] sin_q [3];
	logic signed [15:0] cos_q [3];
	logic signed [15:0] rot_q [9];
	logic signed [29:0] m0_q;
	logic signed [29:0] m1_q;
	logic signed [47:0] macc_q;
	logic [3:0]         idx_q;
	logic [63:0]        sum_q;
	logic [31:0]        mag_q;
	logic signed [31:0] cor_x_q;
	logic signed [31:0] cor_y_q;
	logic signed [17:0] cor_z_q;
	logic               cor_neg_q;
	logic [3:0]         it_q;
	logic               result_valid_q;
	result_t            result_q;

	logic                     mul_start_q;
	logic signed [MUL_W-1:0]  mul_a_q;
	logic signed [MUL_W-1:0]  mul_b_q;
	logic                     mul_done;
	logic signed [PROD_W-1:0] mul_prod;

	logic                sd_start_q;
	sd_mode_t            sd_mode_q;
	logic [SD_NUM_W-1:0] sd_num_q;
	logic [SD_DEN_W-1:0] sd_den_q;
	logic                sd_done;
	logic [SD_NUM_W-1:0] sd_quot;

	logic [1:0]         comp;
	logic signed [31:0] acc_cur;
	logic signed [31:0] vel_cur;
	logic signed [31:0] force_cur;
	logic signed [63:0] prod_shr;
	logic signed [31:0] push_acc;
	logic signed [65:0] drag_term;
	logic signed [31:0] drag_acc;
	logic signed [31:0] vel_sum;
	logic signed [31:0] vel_new;
	logic signed [31:0] acc_clamped;
	logic [63:0]        sum_new;
	logic [63:0]        prod_abs;
	logic signed [31:0] cor_xs;
	logic signed [31:0] cor_ys;
	logic signed [17:0] cor_at;
	logic signed [17:0] z_init;
	mop_t               mop;
	logic signed [MUL_W-1:0] src_a;
	logic signed [MUL_W-1:0] src_b;
	logic signed [47:0] mat_term;
	logic signed [47:0] macc_new;

	function automatic logic signed [MUL_W-1:0] src_val(input src_t s,
			input logic signed [15:0] sp, input logic signed [15:0] cp,
			input logic signed [15:0] sy, input logic signed [15:0] cy,
			input logic signed [15:0] sr, input logic signed [15:0] cr,
			input logic signed [29:0] m0, input logic signed [29:0] m1);
		logic signed [MUL_W-1:0] r;
		case (s)
			SRC_SP:  r = MUL_W'(sp);
			SRC_CP:  r = MUL_W'(cp);
			SRC_SY:  r = MUL_W'(sy);
			SRC_CY:  r = MUL_W'(cy);
			SRC_SR:  r = MUL_W'(sr);
			SRC_CR:  r = MUL_W'(cr);
			SRC_M0:  r = MUL_W'(m0);
			SRC_M1:  r = MUL_W'(m1);
			SRC_ONE: r = MUL_W'(Q14_ONE);
			default: r = '0;
		endcase
		return r;
	endfunction

	rbei_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	rbei_sqdiv u_sqdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sd_start_q),
		.mode   (sd_mode_q),
		.num    (sd_num_q),
		.den    (sd_den_q),
		.done   (sd_done),
		.quot   (sd_quot)
	);

	always_comb begin
		comp = idx_q[1:0];
		acc_cur = acc_q[comp];
		vel_cur = vel_q[comp];
		case (comp)
			2'd0:    force_cur = in_q.force_x;
			2'd1:    force_cur = in_q.force_y;
			default: force_cur = in_q.force_z;
		endcase
		prod_shr = mul_prod >>> FRACTION_BITS;
		push_acc = sat32(66'(acc_cur) + 66'(prod_shr));
		drag_term = $signed({2'b00, sd_quot});
		drag_acc = sat32(vel_cur[31] ? 66'(acc_cur) + drag_term : 66'(acc_cur) - drag_term);
		vel_sum = sat32(66'(vel_cur) + 66'(prod_shr));
		vel_new = clamp_ms(33'(vel_sum), max_speed_q);
		acc_clamped = clamp_ms(33'(acc_cur), max_speed_q);
		sum_new = sum_q + $unsigned(mul_prod);
		prod_abs = mul_prod[63] ? $unsigned(-mul_prod) : $unsigned(mul_prod);

		cor_xs = cor_x_q >>> it_q;
		cor_ys = cor_y_q >>> it_q;
		cor_at = $signed({4'b0000, atan_unit(it_q)});
		z_init = 18'($signed(ang_q[comp]));

		mop = mop_rom(idx_q);
		src_a = src_val(mop.src_a, sin_q[0], cos_q[0], sin_q[1], cos_q[1], sin_q[2],
			cos_q[2], m0_q, m1_q);
		src_b = src_val(mop.src_b, sin_q[0], cos_q[0], sin_q[1], cos_q[1], sin_q[2],
			cos_q[2], m0_q, m1_q);
		mat_term = mop.shl ? (mul_prod[47:0] <<< 14) : mul_prod[47:0];
		if (mop.neg)
			mat_term = -mat_term;
		macc_new = (mop.first ? 48'sd0 : macc_q) + mat_term;
	end

	assign item_stall = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= 31'd65536;
			inv_mass_q <= 31'd65536;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MAX_SPEED: max_speed_q <= cfg_data;
				REG_INV_MASS:  inv_mass_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			result_valid_q <= 1'b0;
			result_q <= '0;
			in_q <= '0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				acc_q[i] <= '0;
				ang_q[i] <= '0;
				sin_q[i] <= '0;
				cos_q[i] <= '0;
			end
			for (int i = 0; i < 9; i++)
				rot_q[i] <= '0;
			m0_q <= '0;
			m1_q <= '0;
			macc_q <= '0;
			idx_q <= '0;
			sum_q <= '0;
			mag_q <= '0;
			cor_x_q <= '0;
			cor_y_q <= '0;
			cor_z_q <= '0;
			cor_neg_q <= 1'b0;
			it_q <= '0;
			mul_start_q <= 1'b0;
			mul_a_q <= '0;
			mul_b_q <= '0;
			sd_start_q <= 1'b0;
			sd_mode_q <= SD_SQRT;
			sd_num_q <= '0;
			sd_den_q <= '0;
		end else begin
			mul_start_q <= 1'b0;
			sd_start_q <= 1'b0;
			if (result_valid_q && !result_stall)
				result_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						in_q <= item;
						idx_q <= '0;
						sum_q <= '0;
						unique case (item.cmd)
							CMD_PUSH:   state_q <= S_PUSH;
							CMD_DRAG:   state_q <= S_SQ;
							CMD_UPDATE: state_q <= S_VEL;
							CMD_TURN: begin
								ang_q[0] <= ang_q[0] + $unsigned(item.turn_pitch);
								ang_q[1] <= ang_q[1] + $unsigned(item.turn_yaw);
								ang_q[2] <= ang_q[2] + $unsigned(item.turn_roll);
							end
							default: ;
						endcase
					end
				end
				S_PUSH: begin
					mul_a_q <= MUL_W'(force_cur);
					mul_b_q <= $signed({2'b00, inv_mass_q});
					mul_start_q <= 1'b1;
					state_q <= S_PUSH_W;
				end
				S_PUSH_W: begin
					if (mul_done) begin
						acc_q[comp] <= push_acc;
						idx_q <= idx_q + 4'd1;
						state_q <= (comp == 2'd2) ? S_IDLE : S_PUSH;
					end
				end
				S_SQ: begin
					mul_a_q <= MUL_W'(vel_cur);
					mul_b_q <= MUL_W'(vel_cur);
					mul_start_q <= 1'b1;
					state_q <= S_SQ_W;
				end
				S_SQ_W: begin
					if (mul_done) begin
						sum_q <= sum_new;
						idx_q <= idx_q + 4'd1;
						if (comp == 2'd2) begin
							sd_mode_q <= SD_SQRT;
							sd_num_q <= sum_new;
							sd_start_q <= 1'b1;
							state_q <= S_ROOT_W;
						end else begin
							state_q <= S_SQ;
						end
					end
				end
				S_ROOT_W: begin
					if (sd_done) begin
						mag_q <= sd_quot[31:0];
						idx_q <= '0;
						if (in_q.cmd == CMD_DRAG) begin
							state_q <= (sd_quot[31:0] == '0) ? S_IDLE : S_DRAG;
						end else begin
							// drop a velocity too slow to matter
							if (sd_quot[31:0] < 32'(THR)) begin
								for (int i = 0; i < 3; i++)
									vel_q[i] <= '0;
							end
							state_q <= S_POS;
						end
					end
				end
				S_DRAG: begin
					mul_a_q <= MUL_W'(vel_cur);
					mul_b_q <= $signed({2'b00, in_q.drag_coefficient});
					mul_start_q <= 1'b1;
					state_q <= S_DRAG_MW;
				end
				S_DRAG_MW: begin
					if (mul_done) begin
						sd_mode_q <= SD_DIV;
						sd_num_q <= prod_abs;
						sd_den_q <= mag_q;
						sd_start_q <= 1'b1;
						state_q <= S_DRAG_DW;
					end
				end
				S_DRAG_DW: begin
					if (sd_done) begin
						acc_q[comp] <= drag_acc;
						idx_q <= idx_q + 4'd1;
						state_q <= (comp == 2'd2) ? S_IDLE : S_DRAG;
					end
				end
				S_VEL: begin
					mul_a_q <= MUL_W'(acc_clamped);
					mul_b_q <= $signed({16'd0, in_q.time_step});
					mul_start_q <= 1'b1;
					state_q <= S_VEL_W;
				end
				S_VEL_W: begin
					if (mul_done) begin
						vel_q[comp] <= vel_new;
						if (comp == 2'd2) begin
							idx_q <= '0;
							sum_q <= '0;
							state_q <= S_SQ;
						end else begin
							idx_q <= idx_q + 4'd1;
							state_q <= S_VEL;
						end
					end
				end
				S_POS: begin
					mul_a_q <= MUL_W'(vel_cur);
					mul_b_q <= $signed({16'd0, in_q.time_step});
					mul_start_q <= 1'b1;
					state_q <= S_POS_W;
				end
				S_POS_W: begin
					if (mul_done) begin
						pos_q[comp] <= pos_q[comp] + prod_shr[31:0];
						acc_q[comp] <= '0;
						if (comp == 2'd2) begin
							idx_q <= '0;
							state_q <= S_CINIT;
						end else begin
							idx_q <= idx_q + 4'd1;
							state_q <= S_POS;
						end
					end
				end
				S_CINIT: begin
					// fold the angle into the half turn the rotations converge on
					if (z_init > 18'sd16384) begin
						cor_z_q <= z_init - 18'sd32768;
						cor_neg_q <= 1'b1;
					end else if (z_init < -18'sd16384) begin
						cor_z_q <= z_init + 18'sd32768;
						cor_neg_q <= 1'b1;
					end else begin
						cor_z_q <= z_init;
						cor_neg_q <= 1'b0;
					end
					cor_x_q <= CORDIC_GAIN;
					cor_y_q <= '0;
					it_q <= '0;
					state_q <= S_CORD;
				end
				S_CORD: begin
					if (cor_z_q >= 18'sd0) begin
						cor_x_q <= cor_x_q - cor_ys;
						cor_y_q <= cor_y_q + cor_xs;
						cor_z_q <= cor_z_q - cor_at;
					end else begin
						cor_x_q <= cor_x_q + cor_ys;
						cor_y_q <= cor_y_q - cor_xs;
						cor_z_q <= cor_z_q + cor_at;
					end
					it_q <= it_q + 4'd1;
					if (it_q == 4'(CORDIC_STEPS - 1))
						state_q <= S_CFIN;
				end
				S_CFIN: begin
					cos_q[comp] <= cordic_round(cor_x_q, cor_neg_q);
					sin_q[comp] <= cordic_round(cor_y_q, cor_neg_q);
					if (comp == 2'd2) begin
						idx_q <= '0;
						state_q <= S_MAT;
					end else begin
						idx_q <= idx_q + 4'd1;
						state_q <= S_CINIT;
					end
				end
				S_MAT: begin
					mul_a_q <= src_a;
					mul_b_q <= src_b;
					mul_start_q <= 1'b1;
					state_q <= S_MAT_W;
				end
				S_MAT_W: begin
					if (mul_done) begin
						macc_q <= macc_new;
						if (mop.dst == DST_M0)
							m0_q <= mul_prod[29:0];
						else if (mop.dst == DST_M1)
							m1_q <= mul_prod[29:0];
						else if (mop.last)
							rot_q[mop.dst] <= q42_to_q14(macc_new);
						idx_q <= idx_q + 4'd1;
						state_q <= (idx_q == 4'(MOP_COUNT - 1)) ? S_EMIT : S_MAT;
					end
				end
				S_EMIT: begin
					// hold until the result register is free
					if (!result_valid_q || !result_stall) begin
						result_q.pos_x <= pos_q[0];
						result_q.pos_y <= pos_q[1];
						result_q.pos_z <= pos_q[2];
						result_q.rot_00 <= rot_q[DST_R00];
						result_q.rot_01 <= rot_q[DST_R01];
						result_q.rot_02 <= rot_q[DST_R02];
						result_q.rot_10 <= rot_q[DST_R10];
						result_q.rot_11 <= rot_q[DST_R11];
						result_q.rot_12 <= rot_q[DST_R12];
						result_q.rot_20 <= rot_q[DST_R20];
						result_q.rot_21 <= rot_q[DST_R21];
						result_q.rot_22 <= rot_q[DST_R22];
						result_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == S_EMIT)
		else $error("result appeared outside the emit step");

	a_no_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> !$rose(result_valid))
		else $error("result appeared right after an item was taken");

	a_update_clears_accel: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> (acc_q[0] == '0 && acc_q[1] == '0 && acc_q[2] == '0 &&
		result.pos_x == pos_q[0] && result.pos_z == pos_q[2]))
		else $error("update result out of step with body state");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the rigid body Euler integrator core.
`timescale 1ns / 1ps

module tb_top;
	import rbei_pkg::*;

	localparam int FRAC = FRACTION_BITS_DEF;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 1200;
	localparam int HOLD_CYCLES = 3000;
	localparam int PHASE_ITEMS = 285;
	localparam logic CFG_MAX_SPEED = 1'b0;
	localparam logic CFG_INV_MASS = 1'b1;
	localparam longint ANGLE_STEP [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41,
		20, 10, 5, 3, 1, 1};

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_write;
	logic        cfg_index;
	logic [30:0] cfg_data;

	rigid_body_euler_integrator_core dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// body state as the predictor sees it
	logic signed [31:0] body_pos [3];
	logic signed [31:0] body_vel [3];
	logic signed [31:0] body_acc [3];
	logic [15:0]        body_ang [3];
	logic [30:0]        speed_bound;
	logic [30:0]        mass_recip;

	result_t pending_results [$];
	int errors;
	int results_seen;
	int cmd_count [4];
	int tx_idle_pct;
	int rx_idle_pct;
	logic hold_request;
	logic hold_done;
	int hold_left;
	int quiet_cycles;

	function automatic longint sat_word(input longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint bound(input longint x, input longint lo, input longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned speed_mag();
		longint unsigned sum;
		longint v;
		longint unsigned a;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			v = body_vel[i];
			a = v < 0 ? -v : v;
			sum += a * a;
		end
		return root_floor(sum);
	endfunction

	function automatic void sin_cos(input logic [15:0] ang, output longint s,
			output longint c);
		longint z;
		longint x;
		longint y;
		longint t;
		logic flip;
		z = longint'($signed(ang));
		x = 163008219;
		y = 0;
		flip = 1'b0;
		if (z > 16384) begin
			z -= 32768;
			flip = 1'b1;
		end else if (z < -16384) begin
			z += 32768;
			flip = 1'b1;
		end
		for (int i = 0; i < 15; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= ANGLE_STEP[i];
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += ANGLE_STEP[i];
			end
			x = t;
		end
		x = bound((x + 8192) >>> 14, -16384, 16384);
		y = bound((y + 8192) >>> 14, -16384, 16384);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic logic signed [15:0] to_q14(input longint v);
		return 16'(bound((v + (64'sd1 <<< 27)) >>> 28, -16384, 16384));
	endfunction

	// advance the body by one item; returns 1 when the item yields a result
	function automatic bit step_body(input item_t it, output result_t r);
		longint a;
		longint v;
		longint d;
		longint ms;
		longint dt;
		longint unsigned mag;
		longint unsigned p;
		longint sp, cp, sy, cy, sr, cr;
		longint one;
		longint f [3];
		logic [15:0] turn [3];
		r = '0;
		f = '{it.force_x, it.force_y, it.force_z};
		turn = '{it.turn_pitch, it.turn_yaw, it.turn_roll};
		case (it.cmd)
			CMD_PUSH: begin
				for (int i = 0; i < 3; i++) begin
					d = (f[i] * longint'(mass_recip)) >>> FRAC;
					body_acc[i] = 32'(sat_word(longint'(body_acc[i]) + d));
				end
				return 1'b0;
			end
			CMD_DRAG: begin
				mag = speed_mag();
				if (mag == 0)
					return 1'b0;
				for (int i = 0; i < 3; i++) begin
					v = body_vel[i];
					p = longint'(v < 0 ? -v : v) * longint'(it.drag_coefficient);
					d = longint'(p / mag);
					if (v < 0)
						d = -d;
					body_acc[i] = 32'(sat_word(longint'(body_acc[i]) - d));
				end
				return 1'b0;
			end
			CMD_TURN: begin
				for (int i = 0; i < 3; i++)
					body_ang[i] = body_ang[i] + turn[i];
				return 1'b0;
			end
			default: begin
				dt = it.time_step;
				ms = speed_bound;
				one = 16384;
				for (int i = 0; i < 3; i++) begin
					a = bound(body_acc[i], -ms, ms);
					v = longint'(body_vel[i]) + ((a * dt) >>> FRAC);
					body_vel[i] = 32'(bound(sat_word(v), -ms, ms));
				end
				if (speed_mag() < ((64'd1 << FRAC) + 50) / 100)
					body_vel = '{0, 0, 0};
				for (int i = 0; i < 3; i++) begin
					d = (longint'(body_vel[i]) * dt) >>> FRAC;
					body_pos[i] = body_pos[i] + 32'(d);
					body_acc[i] = 0;
				end
				sin_cos(body_ang[0], sp, cp);
				sin_cos(body_ang[1], sy, cy);
				sin_cos(body_ang[2], sr, cr);
				r.pos_x = body_pos[0];
				r.pos_y = body_pos[1];
				r.pos_z = body_pos[2];
				r.rot_00 = to_q14(cy * cr * one + sy * sp * sr);
				r.rot_01 = to_q14(-cy * sr * one + sy * sp * cr);
				r.rot_02 = to_q14(sy * cp * one);
				r.rot_10 = to_q14(sr * cp * one);
				r.rot_11 = to_q14(cr * cp * one);
				r.rot_12 = to_q14(-sp * one * one);
				r.rot_20 = to_q14(-sy * cr * one + cy * sp * sr);
				r.rot_21 = to_q14(sr * sy * one + cy * sp * cr);
				r.rot_22 = to_q14(cy * cp * one);
				return 1'b1;
			end
		endcase
	endfunction

	function automatic item_t mk(input cmd_t c, input logic [31:0] fx, input logic [31:0] fy,
			input logic [31:0] fz, input logic [30:0] coef, input logic [15:0] tp,
			input logic [15:0] ty, input logic [15:0] tr, input logic [16:0] dt);
		item_t it;
		it = '{c, fx, fy, fz, coef, tp, ty, tr, dt};
		return it;
	endfunction

	function automatic item_t random_item();
		item_t it;
		int pick;
		it = $bits(item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom});
		pick = $urandom_range(99);
		if (pick < 35)
			it.cmd = CMD_PUSH;
		else if (pick < 50)
			it.cmd = CMD_DRAG;
		else if (pick < 62)
			it.cmd = CMD_TURN;
		else
			it.cmd = CMD_UPDATE;
		// keep most values moderate so the body moves without pinning at the bounds
		if ($urandom_range(9) != 0) begin
			it.force_x = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			it.force_y = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			it.force_z = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			it.drag_coefficient = 31'($urandom_range(0, 1 << 17));
			it.time_step = 17'($urandom_range(0, 8192));
		end else begin
			it.time_step = 17'($urandom_range(0, 65536));
		end
		return it;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result arrived with none expected");
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("pos_x", want.pos_x, result.pos_x);
				check_field("pos_y", want.pos_y, result.pos_y);
				check_field("pos_z", want.pos_z, result.pos_z);
				check_field("rot_00", want.rot_00, result.rot_00);
				check_field("rot_01", want.rot_01, result.rot_01);
				check_field("rot_02", want.rot_02, result.rot_02);
				check_field("rot_10", want.rot_10, result.rot_10);
				check_field("rot_11", want.rot_11, result.rot_11);
				check_field("rot_12", want.rot_12, result.rot_12);
				check_field("rot_20", want.rot_20, result.rot_20);
				check_field("rot_21", want.rot_21, result.rot_21);
				check_field("rot_22", want.rot_22, result.rot_22);
			end
		end
	end

	// result side: random stall, plus one long hold that backs the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else if (hold_request && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_item(input item_t it, input bit use_literal, input result_t literal);
		result_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (item_stall);
		cmd_count[it.cmd]++;
		if (step_body(it, r))
			pending_results.push_back(use_literal ? literal : r);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [30:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		if (idx == CFG_MAX_SPEED)
			speed_bound = val;
		else
			mass_recip = val;
	endtask

	initial begin
		item_t dir_rows [];
		result_t at_rest;
		logic [30:0] ms_set [4];
		logic [30:0] im_set [4];
		int tx_set [4];
		int rx_set [4];
		errors = 0;
		results_seen = 0;
		cmd_count = '{0, 0, 0, 0};
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_request = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_write = 1'b0;
		cfg_index = CFG_MAX_SPEED;
		cfg_data = '0;
		body_pos = '{0, 0, 0};
		body_vel = '{0, 0, 0};
		body_acc = '{0, 0, 0};
		body_ang = '{0, 0, 0};
		speed_bound = 31'd65536;
		mass_recip = 31'd65536;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// at rest after reset: origin and identity rotation
		at_rest = '0;
		at_rest.rot_00 = 16384;
		at_rest.rot_11 = 16384;
		at_rest.rot_22 = 16384;
		dir_rows = '{
			mk(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0, 17'd65536),
			mk(CMD_DRAG, 0, 0, 0, 31'h7FFFFFFF, 0, 0, 0, 0),
			mk(CMD_PUSH, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 0, 0, 0, 0, 0),
			mk(CMD_PUSH, 32'h7FFFFFFF, 32'h80000000, 32'hFFFF0000, 0, 0, 0, 0, 0),
			mk(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0, 17'd65536),
			mk(CMD_DRAG, 0, 0, 0, 31'h7FFFFFFF, 0, 0, 0, 0),
			mk(CMD_DRAG, 0, 0, 0, 31'd0, 0, 0, 0, 0),
			mk(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0, 17'd0),
			mk(CMD_TURN, 0, 0, 0, 0, 16'h7FFF, 16'h8000, 16'h4000, 0),
			mk(CMD_TURN, 0, 0, 0, 0, 16'h7FFF, 16'h8000, 16'hC000, 0),
			mk(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0, 17'd1),
			mk(CMD_TURN, 0, 0, 0, 0, 16'h1234, 16'h4001, 16'hBFFF, 0),
			mk(CMD_PUSH, 32'd300, -32'sd200, 32'd100, 0, 0, 0, 0, 0),
			mk(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0, 17'd65536),
			mk(CMD_PUSH, 32'h00200000, 32'h00100000, -32'sh00080000, 0, 0, 0, 0, 0),
			mk(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0, 17'd32768),
			mk(CMD_DRAG, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'h00010000,
				16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF),
			mk(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0, 17'd4096),
			mk(CMD_TURN, 0, 0, 0, 0, 16'h8000, 16'h7FFF, 16'h0001, 0),
			mk(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0, 17'd65536)
		};
		foreach (dir_rows[k])
			send_item(dir_rows[k], k == 0, at_rest);
		drain();

		ms_set = '{31'd655360, 31'h7FFFFFFF, 31'd0, 31'($urandom)};
		im_set = '{31'd65536, 31'h7FFFFFFF, 31'd1, 31'($urandom_range(1, 1 << 20))};
		tx_set = '{32, 77, 0, 0};
		rx_set = '{77, 32, 0, 0};
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_MAX_SPEED, ms_set[ph]);
			write_reg(CFG_INV_MASS, im_set[ph]);
			tx_idle_pct = tx_set[ph];
			rx_idle_pct = rx_set[ph];
			if (ph == 2)
				hold_request = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_item(random_item(), 1'b0, at_rest);
			drain();
		end

		$display("covered %0d push, %0d drag, %0d turn, %0d update items over 5 register settings",
			cmd_count[CMD_PUSH], cmd_count[CMD_DRAG], cmd_count[CMD_TURN],
			cmd_count[CMD_UPDATE]);
		$display("checked %0d results, %0d mismatches", results_seen, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
